// File: hw/rtl/fixed_block_pool_allocator_assert.svh
// Assertion macros for the fixed block pool allocator.
// Included by the RTL modules that carry concurrent checks; needs no package.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define FBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define FBP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBP_ASSERT(lbl, prop, msg)
`define FBP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/fbp_pkg.sv
// Shared types and codes of the fixed block pool allocator.
// Used by the front end, the command queue, the back end and the top level.
package fbp_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Request modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_REINIT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BYTES  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_ALIGN = 3'd3,
    ST_FULL  = 3'd4
  } fbp_status_t;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_REINIT,
    CMD_RANGE,
    CMD_NOP
  } fbp_cmd_kind_t;

  typedef struct packed {
    fbp_cmd_kind_t kind;
    logic [31:0]   offset;
  } fbp_cmd_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [15:0] block_bytes;
    logic [8:0]  block_count;
  } fbp_cfg_t;

endpackage

// File: hw/rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: configuration registers and wiring
// of front end, command queue and back end. Depends on fbp_pkg and the submodules.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_mode, in_block_address
//   out_     output     out_valid/out_stall out_status, out_granted_address,
//                                          out_blocks_free
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// A request passes through the front end and the command queue, then the back end runs it:
// an allocate from a non-empty pool goes through stack read, multiply, add and result; a free
// in range goes through the one-bit-per-cycle restoring divider, a check and the result;
// other requests go straight to the result. Reset needs no clearing pass: a
// low-water mark tells written stack entries from untouched ones. The front end
// keeps taking requests while a result waits for out_stall to drop, until the queue is full.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = fbp_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_granted_address,
  output logic [8:0]  out_blocks_free,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import fbp_pkg::*;

  fbp_cfg_t cfg_r;
  logic     push_valid;
  logic     push_ready;
  fbp_cmd_t push_cmd;
  logic     pop_valid;
  logic     pop_ready;
  fbp_cmd_t pop_cmd;

  // Write configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address <= 32'd0;
      cfg_r.block_bytes  <= 16'd64;
      cfg_r.block_count  <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_ADDRESS: cfg_r.base_address <= cfg_wdata;
        CFG_BLOCK_BYTES:  cfg_r.block_bytes  <= cfg_wdata[15:0];
        CFG_BLOCK_COUNT:  cfg_r.block_count  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  fbp_front #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_block_address (in_block_address),
    .cmd_valid        (push_valid),
    .cmd_ready        (push_ready),
    .cmd              (push_cmd)
  );

  fbp_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  fbp_back #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd_valid           (pop_valid),
    .cmd_ready           (pop_ready),
    .cmd                 (pop_cmd),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_blocks_free     (out_blocks_free)
  );

endmodule

// File: hw/rtl/fbp_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on fbp_pkg for the command type and the queue depth.
module fbp_cmd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  fbp_pkg::fbp_cmd_t push_cmd,
  output logic             pop_valid,
  input  logic             pop_ready,
  output fbp_pkg::fbp_cmd_t pop_cmd
);
  import fbp_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  fbp_cmd_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [NW-1:0]   fill_r;
  logic            push_fire;
  logic            pop_fire;

  // Flag full and empty
  assign push_ready = (fill_r != NW'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push_fire  = push_valid & push_ready;
  assign pop_fire   = pop_valid & pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // Store command payload
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/fbp_front.sv
// Front end: takes requests, runs the region range check and classifies them.
// Depends on fbp_pkg for modes, command and configuration types.
module fbp_front #(
  parameter int unsigned MAX_BLOCKS = fbp_pkg::MAX_BLOCKS_DEF
) (
  input  fbp_pkg::fbp_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [31:0]       in_block_address,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output fbp_pkg::fbp_cmd_t cmd
);
  import fbp_pkg::*;

  localparam int unsigned FW        = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SPW       = FW + 16;
  localparam int unsigned CW        = (SPW > 32) ? SPW : 32;
  localparam logic [31:0] MAX_W     = 32'(MAX_BLOCKS);

  logic [FW-1:0]  eff_count;
  logic [SPW-1:0] span;
  logic [31:0]    offset;
  logic           out_of_range;

  // Clamp the block count to the pool size
  assign eff_count = ({23'd0, cfg.block_count} > MAX_W) ? FW'(MAX_BLOCKS)
                                                        : FW'(cfg.block_count);

  // Size the region in bytes from the live configuration
  assign span = SPW'(eff_count) * SPW'(cfg.block_bytes);

  // Classify the request
  always_comb begin
    offset       = in_block_address - cfg.base_address;
    out_of_range = (in_block_address < cfg.base_address) ||
                   (CW'(offset) >= CW'(span));
    cmd.offset   = offset;
    case (in_mode)
      MODE_ALLOC:  cmd.kind = CMD_ALLOC;
      MODE_FREE:   cmd.kind = out_of_range ? CMD_RANGE : CMD_FREE;
      MODE_REINIT: cmd.kind = CMD_REINIT;
      default:     cmd.kind = CMD_NOP;
    endcase
  end

  // Transfer into the queue whenever it has room
  assign cmd_valid = in_valid;
  assign in_stall  = !cmd_ready;

endmodule

// File: hw/rtl/fbp_back.sv
// Back end: free stack memory, low-water mark, divider and result register.
// Depends on fbp_pkg and the assertion macro header.
`include "fixed_block_pool_allocator_assert.svh"
module fbp_back #(
  parameter int unsigned MAX_BLOCKS = fbp_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fbp_pkg::fbp_cfg_t cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  fbp_pkg::fbp_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [31:0]       out_granted_address,
  output logic [8:0]        out_blocks_free
);
  import fbp_pkg::*;

  localparam int unsigned IW        = $clog2(MAX_BLOCKS);
  localparam int unsigned FW        = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned DW        = 16 + IW;
  localparam int unsigned CMPW      = (DW > 32) ? DW : 32;
  localparam int unsigned LW        = $clog2(IW + 1);
  localparam int unsigned INIT_FREE = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam logic [31:0] MAX_W     = 32'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV,
    S_CHECK,
    S_RESP
  } state_t;

  state_t        state_r;
  logic [FW-1:0] ft_r;        // free total
  logic [FW-1:0] low_r;       // lowest free total since reinit
  logic [IW-1:0] pos_r;
  logic          hit_r;       // popped entry was written since reinit
  logic [IW-1:0] rd_data_r;
  logic [DW-1:0] prod_r;
  logic [31:0]   rem_r;
  logic [DW-1:0] dsh_r;
  logic [IW-1:0] quo_r;
  logic [LW-1:0] left_r;
  fbp_status_t   status_r;
  logic [31:0]   granted_r;
  logic [IW-1:0] stack_mem [MAX_BLOCKS];

  logic [FW-1:0] eff_count;
  logic [FW-1:0] ft_dec;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          mem_we;
  logic          div_ge;
  logic [IW-1:0] idx_sel;

  // Derive addresses, compare and select
  always_comb begin
    eff_count = ({23'd0, cfg.block_count} > MAX_W) ? FW'(MAX_BLOCKS)
                                                   : FW'(cfg.block_count);
    ft_dec    = ft_r - 1'b1;
    rd_addr   = ft_dec[IW-1:0];
    wr_addr   = ft_r[IW-1:0];
    mem_we    = (state_r == S_CHECK) && (rem_r == '0) && (ft_r < eff_count);
    div_ge    = (CMPW'(rem_r) >= CMPW'(dsh_r));
    idx_sel   = hit_r ? rd_data_r : pos_r;
  end

  // Free stack: push at the top, read the entry just below the top
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= quo_r;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  // Sequence one command at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ft_r      <= FW'(INIT_FREE);
      low_r     <= FW'(INIT_FREE);
      status_r  <= ST_OK;
      granted_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            status_r  <= ST_OK;
            granted_r <= '0;
            case (cmd.kind)
              CMD_ALLOC: begin
                if (ft_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_RESP;
                end else begin
                  ft_r  <= ft_dec;
                  pos_r <= ft_dec[IW-1:0];
                  hit_r <= (ft_dec >= low_r);
                  if (ft_dec < low_r) begin
                    low_r <= ft_dec;
                  end
                  state_r <= S_MUL;
                end
              end
              CMD_FREE: begin
                rem_r   <= cmd.offset;
                dsh_r   <= DW'(cfg.block_bytes) << (IW - 1);
                quo_r   <= '0;
                left_r  <= LW'(IW);
                state_r <= S_DIV;
              end
              CMD_REINIT: begin
                ft_r    <= eff_count;
                low_r   <= eff_count;
                state_r <= S_RESP;
              end
              CMD_RANGE: begin
                status_r <= ST_RANGE;
                state_r  <= S_RESP;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= DW'(idx_sel) * DW'(cfg.block_bytes);
          state_r <= S_ADD;
        end
        S_ADD: begin
          granted_r <= cfg.base_address + 32'(prod_r);
          state_r   <= S_RESP;
        end
        S_DIV: begin
          // One restoring division step per cycle, quotient MSB first
          if (div_ge) begin
            rem_r <= rem_r - 32'(dsh_r);
          end
          quo_r  <= IW'({quo_r, div_ge});
          dsh_r  <= dsh_r >> 1;
          left_r <= left_r - 1'b1;
          if (left_r == LW'(1)) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rem_r != '0) begin
            status_r <= ST_ALIGN;
          end else if (ft_r >= eff_count) begin
            status_r <= ST_FULL;
          end else begin
            ft_r <= ft_r + 1'b1;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Drive handshake and result
  assign cmd_ready           = (state_r == S_IDLE);
  assign out_valid           = (state_r == S_RESP);
  assign out_status          = status_r;
  assign out_granted_address = granted_r;
  assign out_blocks_free     = 9'(ft_r);

  `FBP_ASSERT(a_free_total_bound, ft_r <= FW'(MAX_BLOCKS), "free total above pool size")
  `FBP_ASSERT(a_low_water_order, low_r <= ft_r, "low-water mark above free total")
  `FBP_ASSERT(a_push_advances, mem_we |=> ft_r == FW'($past(ft_r) + 1'b1), "push lost")
  `FBP_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == S_IDLE, "not idle after reset")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_block_pool_allocator: directed and random requests
// against a cycle-free predictor of the free stack. Needs fbp_pkg and the allocator RTL.
module tb;
  import fbp_pkg::*;

  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 1000000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SQUARE
  } stall_style_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted;
    logic [8:0]  blocks_free;
  } pool_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_ALLOC;
  logic [31:0] in_block_address = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_granted_address;
  logic [8:0]  out_blocks_free;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BASE_ADDRESS;
  logic [31:0] cfg_wdata = 32'd0;

  // Predicted pool state and register copies
  logic [31:0] pool_base;
  logic [15:0] pool_bytes;
  logic [8:0]  pool_count;
  logic [7:0]  stack_idx [MAX_BLOCKS_DEF];
  bit          stack_set [MAX_BLOCKS_DEF];
  logic [8:0]  pool_free;

  pool_result_t expected_results[$];
  logic [31:0]  granted_pool[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;
  stall_style_t stall_style = STALL_NONE;
  logic [7:0]   stall_tick = 8'd0;

  fixed_block_pool_allocator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_blocks_free     (out_blocks_free),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp the configured count to the stack depth
  function automatic logic [8:0] live_blocks();
    return (pool_count > 9'd256) ? 9'd256 : pool_count;
  endfunction

  // Apply one request to the predicted pool and return the result it causes
  function automatic pool_result_t predict_request(input logic [1:0] mode,
                                                   input logic [31:0] addr);
    pool_result_t res;
    logic [8:0]   cnt;
    logic [7:0]   idx;
    logic [31:0]  off;
    logic [63:0]  span;
    logic [63:0]  wide;
    res.status  = ST_OK;
    res.granted = 32'd0;
    cnt = live_blocks();
    case (mode)
      MODE_ALLOC: begin
        if (pool_free == 9'd0) begin
          res.status = ST_EMPTY;
        end else begin
          pool_free = pool_free - 9'd1;
          // untouched entries read as their own position
          idx = stack_set[pool_free[7:0]] ? stack_idx[pool_free[7:0]] : pool_free[7:0];
          wide = {32'd0, pool_base} + {56'd0, idx} * {48'd0, pool_bytes};
          res.granted = wide[31:0];
        end
      end
      MODE_FREE: begin
        span = {55'd0, cnt} * {48'd0, pool_bytes};
        off  = addr - pool_base;
        if (addr < pool_base || {32'd0, off} >= span) begin
          res.status = ST_RANGE;
        end else if (off % {16'd0, pool_bytes} != 32'd0) begin
          res.status = ST_ALIGN;
        end else if (pool_free >= cnt) begin
          res.status = ST_FULL;
        end else begin
          wide = {32'd0, off / {16'd0, pool_bytes}};
          stack_idx[pool_free[7:0]] = wide[7:0];
          stack_set[pool_free[7:0]] = 1'b1;
          pool_free = pool_free + 9'd1;
        end
      end
      MODE_REINIT: begin
        foreach (stack_set[i]) stack_set[i] = 1'b0;
        pool_free = cnt;
      end
      default: ;
    endcase
    res.blocks_free = pool_free;
    return res;
  endfunction

  // Send one request in bursts, with random gaps when gaps are on; predict it on transfer
  task automatic send_item(input logic [1:0] mode, input logic [31:0] addr);
    pool_result_t res;
    if (burst_left == 0) begin
      burst_left = gaps_on ? $urandom_range(1, 16) : 1000000;
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_block_address <= addr;
    do @(posedge clk); while (in_stall);
    res = predict_request(mode, addr);
    expected_results.push_back(res);
    if (mode == MODE_REINIT) granted_pool.delete();
    if (mode == MODE_ALLOC && res.status == ST_OK) granted_pool.push_back(res.granted);
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic wait_results_done();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Write one register; keep valid high when another write follows
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE_ADDRESS: pool_base  = data;
      CFG_BLOCK_BYTES:  pool_bytes = data[15:0];
      CFG_BLOCK_COUNT:  pool_count = data[8:0];
      default: ;
    endcase
    if (!hold) cfg_valid <= 1'b0;
  endtask

  task automatic configure_pool(input logic [31:0] base, input logic [15:0] bytes,
                                input logic [8:0] count);
    wait_results_done();
    cfg_write(CFG_BASE_ADDRESS, base, 1'b1);
    cfg_write(CFG_BLOCK_BYTES, {16'd0, bytes}, 1'b1);
    cfg_write(CFG_BLOCK_COUNT, {23'd0, count}, 1'b0);
    granted_pool.delete();
  endtask

  // Reset defaults: 256 blocks of 64 bytes at address 0
  task automatic test_alloc_free_basics();
    send_item(MODE_ALLOC, 32'h0000_0000);
    send_item(MODE_ALLOC, 32'hFFFF_FFFF);
    send_item(MODE_FREE, 32'h0000_3FC0);
    // double free is taken while the pool is not full
    send_item(MODE_FREE, 32'h0000_3FC0);
    send_item(MODE_FREE, 32'h0000_0000);
    send_item(MODE_FREE, 32'h0000_4000);
    send_item(MODE_FREE, 32'h0000_3FFF);
    send_item(MODE_FREE, 32'hFFFF_FFFF);
    send_item(MODE_UNKNOWN, 32'hA5A5_5A5A);
    send_item(MODE_REINIT, 32'h5A5A_A5A5);
  endtask

  // High base, largest block size, count lowered without reinitializing
  task automatic test_region_edges();
    configure_pool(32'h8000_0000, 16'hFFFF, 9'd2);
    send_item(MODE_FREE, 32'h7FFF_FFFF);
    send_item(MODE_FREE, 32'h8000_FFFF);
    send_item(MODE_ALLOC, 32'h0000_0000);
    send_item(MODE_REINIT, 32'h0000_0000);
    send_item(MODE_ALLOC, 32'h0000_0000);
    send_item(MODE_ALLOC, 32'h0000_0000);
    send_item(MODE_ALLOC, 32'h0000_0000);
    send_item(MODE_FREE, 32'h8000_0001);
    send_item(MODE_FREE, 32'h8001_FFFE);
    send_item(MODE_FREE, 32'h8000_FFFF);
  endtask

  // Zero block size, zero count, count beyond the stack depth
  task automatic test_degenerate_sizes();
    wait_results_done();
    cfg_write(CFG_UNUSED, 32'hDEAD_BEEF, 1'b1);
    configure_pool(32'h0000_1234, 16'd0, 9'd5);
    send_item(MODE_REINIT, 32'h0000_0000);
    send_item(MODE_ALLOC, 32'h0000_0000);
    send_item(MODE_FREE, 32'h0000_1234);
    configure_pool(32'h0000_1234, 16'd8, 9'd0);
    send_item(MODE_REINIT, 32'h0000_0000);
    send_item(MODE_ALLOC, 32'h0000_0000);
    send_item(MODE_FREE, 32'h0000_1234);
    configure_pool(32'h0000_0000, 16'd1, 9'd511);
    send_item(MODE_REINIT, 32'h0000_0000);
  endtask

  // Phases of mostly well-formed alloc/free traffic with some noise
  task automatic test_random_traffic();
    logic [31:0] base;
    logic [15:0] bytes;
    logic [8:0]  count;
    logic [31:0] addr;
    int          alloc_bias;
    int          pick;
    int          k;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      base  = $urandom;
      bytes = 16'($urandom_range(1, 65535));
      count = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(1, 256))
                                          : 9'($urandom_range(1, 32));
      case (phase)
        0: begin
          base = 32'd0; bytes = 16'd64; count = 9'd256;
        end
        1: begin
          base = 32'hFFFF_FFFF; bytes = 16'd1; count = 9'd1;
        end
        2: begin
          base = 32'hFFFF_0000; bytes = 16'hFFFF; count = 9'd256;
        end
        3: count = 9'($urandom_range(1, 8));
        4: count = 9'($urandom_range(257, 511));
        5: bytes = 16'd1;
        6: bytes = 16'($urandom_range(1, 16));
        default: ;
      endcase
      configure_pool(base, bytes, count);
      gaps_on    = ($urandom_range(0, 3) != 0);
      alloc_bias = $urandom_range(25, 60);
      // leave the stack as it is now and then
      if (phase == 0 || $urandom_range(0, 3) != 0) send_item(MODE_REINIT, $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, live_blocks() - 1);
        if (pick < alloc_bias) begin
          send_item(MODE_ALLOC, $urandom);
        end else if (pick < 85 && granted_pool.size() != 0) begin
          k    = $urandom_range(0, granted_pool.size() - 1);
          addr = granted_pool[k];
          granted_pool.delete(k);
          send_item(MODE_FREE, addr);
        end else if (pick < 90) begin
          send_item(MODE_FREE, pool_base + k * pool_bytes);
        end else if (pick < 94 && pool_bytes > 16'd1) begin
          send_item(MODE_FREE, pool_base + k * pool_bytes + $urandom_range(1, pool_bytes - 1));
        end else if (pick < 97) begin
          send_item(MODE_FREE, $urandom);
        end else if (pick < 99) begin
          send_item(MODE_REINIT, $urandom);
        end else begin
          send_item(MODE_UNKNOWN, $urandom);
        end
        // drain completely once in a while
        if ($urandom_range(0, 63) == 0) wait_results_done();
      end
    end
  endtask

  // Receiver stall pattern, restyled whenever the low seven bits of stall_tick are zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[6:0] == 7'd0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_tick[2];
    endcase
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d granted=%h free=%0d", $time,
                 out_status, out_granted_address, out_blocks_free);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_granted_address !== want.granted) begin
          $display("%0t: granted_address expected %h actual %h", $time, want.granted,
                   out_granted_address);
          fail_count++;
        end
        if (out_blocks_free !== want.blocks_free) begin
          $display("%0t: blocks_free expected %0d actual %0d", $time, want.blocks_free,
                   out_blocks_free);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    pool_base   = 32'd0;
    pool_bytes  = 16'd64;
    pool_count  = 9'd256;
    pool_free   = 9'd256;
    foreach (stack_set[i]) begin
      stack_set[i] = 1'b0;
      stack_idx[i] = 8'd0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_alloc_free_basics();
    test_region_edges();
    test_degenerate_sizes();
    test_random_traffic();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
